[sv/tilt_complementary_filter_top_assert.svh]
// ---------------------------------------------------------------------------
// Tilt complementary filter assertion macros
// Shorthand for clocked implications used by the top level checks.
// ---------------------------------------------------------------------------
`ifndef TILT_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define TCF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tcf_pkg.sv]
// ---------------------------------------------------------------------------
// Tilt complementary filter package
// Item, result and job types, fixed constants and the CORDIC angle table.
// ---------------------------------------------------------------------------
package tcf_pkg;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic [15:0]        elapsed_us;
		logic               home_press;
		logic               lock_press;
	} item_t;

	typedef struct packed {
		logic signed [31:0] roll_deg;
		logic signed [31:0] pitch_deg;
		logic signed [31:0] yaw_deg;
		logic               is_locked;
	} result_t;

	typedef struct packed {
		logic locked;
		logic capture;
		logic serve_home;
	} tag_t;

	typedef struct packed {
		item_t item;
		tag_t  tag;
	} job_t;

	localparam int QDepth   = 2;
	localparam int QPtrW    = 1;
	localparam int AtanSteps = 24;

	// Dividing by one million is a shift by six and a reciprocal multiply by 2^49 / 15625.
	localparam logic [35:0]        RecipConst = 36'd36028797019;
	localparam logic [37:0]        RoundBias  = 38'd7812;
	localparam logic signed [32:0] Deg180    = 33'sd11796480;
	localparam logic signed [32:0] Deg360    = 33'sd23592960;

	function automatic logic [21:0] atan_entry(input logic [4:0] idx);
		logic [21:0] v;
		unique case (idx)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		logic signed [31:0] r;
		if (v > 52'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -52'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[sv/tcf_front.sv]
// ---------------------------------------------------------------------------
// Tilt complementary filter front end
// Accepts samples and tags each with its lock and home handling.
// ---------------------------------------------------------------------------
module tcf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcf_pkg::item_t item,
	input  logic          q_full,
	output logic          full,
	output logic          q_wr,
	output tcf_pkg::job_t  q_data
);
	import tcf_pkg::*;

	logic lock_q;
	logic home_q;
	logic lock_next;
	logic home_pend;

	assign full      = q_full;
	assign q_wr      = push && !q_full;
	assign lock_next = lock_q ^ item.lock_press;
	assign home_pend = home_q | item.home_press;

	always_comb begin
		q_data.item           = item;
		q_data.tag.locked     = lock_next;
		q_data.tag.capture    = item.lock_press && lock_next;
		q_data.tag.serve_home = !lock_next && home_pend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= 1'b0;
			home_q <= 1'b0;
		end else if (q_wr) begin
			lock_q <= lock_next;
			home_q <= lock_next ? home_pend : 1'b0;
		end
	end

endmodule

[sv/tcf_queue.sv]
// ---------------------------------------------------------------------------
// Tilt complementary filter job queue
// Short first-in first-out buffer between the front end and the engine.
// ---------------------------------------------------------------------------
module tcf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  tcf_pkg::job_t  wr_data,
	input  logic          rd,
	output tcf_pkg::job_t  rd_data,
	output logic          q_full,
	output logic          q_empty
);
	import tcf_pkg::*;

	job_t             mem_q [QDepth];
	logic [QPtrW-1:0] wp_q;
	logic [QPtrW-1:0] rp_q;
	logic [QPtrW:0]   cnt_q;

	assign q_full  = (cnt_q == QDepth[QPtrW:0]);
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[sv/tcf_back.sv]
// ---------------------------------------------------------------------------
// Tilt complementary filter engine
// Runs gyro division, square root, CORDIC and blend for one job at a time.
// ---------------------------------------------------------------------------
module tcf_back #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tcf_pkg::job_t    job,
	input  logic            q_empty,
	output logic            q_pop,
	input  logic [15:0]     weight,
	output tcf_pkg::result_t result,
	output logic            empty,
	input  logic            pop,
	output logic            idle
);
	import tcf_pkg::*;

	localparam int Steps = (CORDIC_STEPS > AtanSteps) ? AtanSteps : CORDIC_STEPS;
	localparam int CW    = 34;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_CORD = 3'd3;
	localparam logic [2:0] ST_WRAP = 3'd4;
	localparam logic [2:0] ST_MULT = 3'd5;
	localparam logic [2:0] ST_SUM  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	job_t       job_q;

	logic [37:0] num_q [3];
	logic [74:0] acc_q [3];
	logic        neg_q [3];

	logic [59:0] n_q;
	logic [59:0] res_q;

	logic signed [CW-1:0] rx_q, ry_q, px_q, py_q;
	logic signed [31:0]   rz_q, pz_q;
	logic                 rzero_q, pzero_q;

	logic signed [31:0] roll_q, pitch_q, yaw_q;
	logic signed [31:0] roff_q, poff_q, hroll_q, hpitch_q;
	logic signed [25:0] accr_q, accp_q;
	logic signed [25:0] stp_q [3];
	logic signed [51:0] m1r_q, m2r_q, m1p_q, m2p_q;

	result_t res_out_q;
	logic    out_valid_q;

	logic signed [15:0] rate [3];
	logic signed [32:0] prod [3];
	logic [31:0]        mag [3];
	logic [6:0]         sh;
	logic [59:0]        bitv;
	logic [59:0]        sq_sum;
	logic               sq_ge;
	logic signed [CW-1:0] ax0, ay0, az0;
	logic [4:0]           ci;
	logic signed [CW-1:0] rxs, rys, pxs, pys;
	logic signed [31:0]   atv;
	logic signed [31:0]   raw_r, raw_p;
	logic signed [32:0]   dr, dp;
	logic signed [32:0]   wr1, wp1, wr2, wp2;
	logic signed [32:0]   sr, sp;
	logic signed [17:0]   aw;
	logic signed [51:0]   vr, vp;
	logic signed [51:0]   ysum;
	logic                 out_free;

	function automatic logic signed [32:0] wrap_once(input logic signed [32:0] d);
		logic signed [32:0] r;
		if (d > Deg180) begin
			r = d - Deg360;
		end else if (d < -Deg180) begin
			r = d + Deg360;
		end else begin
			r = d;
		end
		return r;
	endfunction

	assign empty    = !out_valid_q;
	assign result   = res_out_q;
	assign idle     = (state_q == ST_IDLE);
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign out_free = !out_valid_q || pop;

	assign rate[0] = job_q.item.rate_x;
	assign rate[1] = job_q.item.rate_y;
	assign rate[2] = job_q.item.rate_z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = rate[k] * $signed({1'b0, job_q.item.elapsed_us});
			mag[k]  = prod[k][32] ? 32'(-prod[k]) : prod[k][31:0];
		end
	end

	assign sh     = 7'd58 - {cnt_q, 1'b0};
	assign bitv   = 60'd1 << sh;
	assign sq_sum = res_q + bitv;
	assign sq_ge  = (n_q >= sq_sum);

	assign ax0 = CW'(job_q.item.accel_x) <<< 14;
	assign ay0 = CW'(job_q.item.accel_y) <<< 14;
	assign az0 = CW'(job_q.item.accel_z) <<< 14;

	assign ci  = cnt_q[4:0];
	assign rxs = rx_q >>> ci;
	assign rys = ry_q >>> ci;
	assign pxs = px_q >>> ci;
	assign pys = py_q >>> ci;
	assign atv = $signed({10'd0, atan_entry(ci)});

	assign raw_r = rzero_q ? 32'sd0 : rz_q;
	assign raw_p = pzero_q ? 32'sd0 : pz_q;
	assign dr    = job_q.tag.serve_home ? 33'sd0 : (33'(raw_r) - 33'(roff_q));
	assign dp    = job_q.tag.serve_home ? 33'sd0 : (33'(raw_p) - 33'(poff_q));
	assign wr1   = wrap_once(dr);
	assign wr2   = wrap_once(wr1);
	assign wp1   = wrap_once(dp);
	assign wp2   = wrap_once(wp1);

	assign sr   = 33'(roll_q) + 33'(stp_q[0]);
	assign sp   = 33'(pitch_q) + 33'(stp_q[1]);
	assign aw   = 18'sd65536 - $signed({2'b0, weight});
	assign vr   = m1r_q + m2r_q + 52'sd32768;
	assign vp   = m1p_q + m2p_q + 52'sd32768;
	assign ysum = 52'(yaw_q) + 52'(stp_q[2]);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				job_q <= job;
			end
			ST_MUL: begin
				for (int k = 0; k < 3; k++) begin
					num_q[k] <= {mag[k], 6'd0} + RoundBias;
					neg_q[k] <= prod[k][32];
				end
				n_q   <= 60'(32'(job_q.item.accel_y * job_q.item.accel_y)
					+ 32'(job_q.item.accel_z * job_q.item.accel_z)) << 28;
				res_q <= '0;
				rzero_q <= (job_q.item.accel_y == 16'sd0) && (job_q.item.accel_z == 16'sd0);
				if (az0 < 0) begin
					rx_q <= -az0;
					ry_q <= -ay0;
					rz_q <= (ay0 >= 0) ? Deg180[31:0] : -Deg180[31:0];
				end else begin
					rx_q <= az0;
					ry_q <= ay0;
					rz_q <= '0;
				end
			end
			ST_DIV: begin
				for (int k = 0; k < 3; k++) begin
					if (cnt_q == 6'd0) begin
						acc_q[k] <= 75'(num_q[k][18:0] * RecipConst);
					end else if (cnt_q == 6'd1) begin
						acc_q[k] <= acc_q[k] + (75'(num_q[k][37:19] * RecipConst) << 19);
					end
				end
				if (cnt_q < 6'd30) begin
					if (sq_ge) begin
						n_q   <= n_q - sq_sum;
						res_q <= (res_q >> 1) + bitv;
					end else begin
						res_q <= res_q >> 1;
					end
				end
				if (cnt_q == 6'd30) begin
					px_q    <= CW'(res_q[30:0]);
					py_q    <= -ax0;
					pz_q    <= '0;
					pzero_q <= (res_q == '0) && (job_q.item.accel_x == 16'sd0);
				end
			end
			ST_CORD: begin
				if (ry_q > 0) begin
					rx_q <= rx_q + rys;
					ry_q <= ry_q - rxs;
					rz_q <= rz_q + atv;
				end else begin
					rx_q <= rx_q - rys;
					ry_q <= ry_q + rxs;
					rz_q <= rz_q - atv;
				end
				if (py_q > 0) begin
					px_q <= px_q + pys;
					py_q <= py_q - pxs;
					pz_q <= pz_q + atv;
				end else begin
					px_q <= px_q - pys;
					py_q <= py_q + pxs;
					pz_q <= pz_q - atv;
				end
			end
			ST_WRAP: begin
				accr_q <= wr2[25:0];
				accp_q <= wp2[25:0];
				for (int k = 0; k < 3; k++) begin
					stp_q[k] <= neg_q[k] ? -$signed({2'b0, acc_q[k][72:49]})
						: $signed({2'b0, acc_q[k][72:49]});
				end
			end
			ST_MULT: begin
				m1r_q <= 52'($signed({1'b0, weight}) * sr);
				m1p_q <= 52'($signed({1'b0, weight}) * sp);
				m2r_q <= 52'(aw * accr_q);
				m2p_q <= 52'(aw * accp_q);
			end
			ST_SUM, ST_DONE: begin
			end
			default: begin
			end
		endcase
		if ((state_q == ST_DONE) && out_free) begin
			res_out_q.roll_deg  <= roll_q;
			res_out_q.pitch_deg <= pitch_q;
			res_out_q.yaw_deg   <= yaw_q;
			res_out_q.is_locked <= job_q.tag.locked;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			roll_q      <= '0;
			pitch_q     <= '0;
			yaw_q       <= '0;
			roff_q      <= '0;
			poff_q      <= '0;
			hroll_q     <= '0;
			hpitch_q    <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (job.tag.locked) begin
							if (job.tag.capture) begin
								hroll_q  <= roll_q;
								hpitch_q <= pitch_q;
							end else begin
								roll_q  <= hroll_q;
								pitch_q <= hpitch_q;
							end
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == 6'd30) begin
						cnt_q   <= '0;
						state_q <= ST_CORD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CORD: begin
					if (cnt_q == 6'(Steps - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_WRAP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WRAP: begin
					if (job_q.tag.serve_home) begin
						roff_q  <= raw_r;
						poff_q  <= raw_p;
						roll_q  <= '0;
						pitch_q <= '0;
						yaw_q   <= '0;
					end
					state_q <= ST_MULT;
				end
				ST_MULT: begin
					yaw_q   <= sat32(ysum);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					roll_q  <= sat32(vr >>> 16);
					pitch_q <= sat32(vp >>> 16);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/tilt_complementary_filter_top.sv]
// ---------------------------------------------------------------------------
// Tilt complementary filter
// Estimates roll, pitch and yaw from one IMU sample per word.
// ---------------------------------------------------------------------------
// Samples enter a two-word queue and are processed one at a time. In the engine an
// unlocked sample runs the square root loop, which also covers the reciprocal
// multiply of the gyro steps, followed by the CORDIC iterations and the blend.
// A sample that arrives while the view is locked skips these steps. Results wait
// in an output register while the queue keeps accepting samples until it is full.
module tilt_complementary_filter_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  tcf_pkg::item_t    item,
	output logic             empty,
	input  logic             pop,
	output tcf_pkg::result_t  result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [15:0]      cfg_data
);
	import tcf_pkg::*;

	`include "tilt_complementary_filter_top_assert.svh"

	logic [15:0] weight_q;
	logic        q_full;
	logic        q_empty;
	logic        q_wr;
	logic        q_pop;
	logic        back_idle;
	job_t        q_in;
	job_t        q_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= 16'd64225;
		end else if (cfg_valid && cfg_ready) begin
			weight_q <= cfg_data;
		end
	end

	tcf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.q_full (q_full),
		.full   (full),
		.q_wr   (q_wr),
		.q_data (q_in)
	);

	tcf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_in),
		.rd      (q_pop),
		.rd_data (q_out),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	tcf_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (q_out),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.weight  (weight_q),
		.result  (result),
		.empty   (empty),
		.pop     (pop),
		.idle    (back_idle)
	);

	`TCF_ASSERT_NOW(a_pop_when_idle, q_pop, back_idle && !q_empty, "engine took a job while busy")
	`TCF_ASSERT_NEXT(a_push_fills_queue, push && !full, !q_empty, "accepted word missing from queue")
	`TCF_ASSERT_NOW(a_full_blocks_write, q_full, !q_wr, "queue written while full")

endmodule
